[design/prc_pkg.sv]
// prc_pkg: shared widths, factorial constants and control types for the
// permutation rank codec. No dependencies.
package prc_pkg;

  localparam int ELEM_COUNT_DEFAULT = 9;
  localparam int NIB_W      = 4;
  localparam int NIB_COUNT  = 9;
  localparam int RANK_W     = 19;
  localparam int PERM_W     = NIB_W * NIB_COUNT;
  // rank path: lane count, lane product, merge sum
  localparam int RANK_LAT   = 3;

  typedef enum logic {
    ACT_RANK   = 1'b0,
    ACT_UNRANK = 1'b1
  } prc_action_t;

  typedef struct packed {
    logic        vld;
    prc_action_t act;
    logic        err;
  } prc_ctl_t;

  // n! for elaboration-time constants
  function automatic logic [63:0] fact(input int n);
    logic [63:0] f;
    f = 64'd1;
    for (int k = 2; k <= n; k++) begin
      f = f * 64'(k);
    end
    return f;
  endfunction

endpackage

[design/prc_rank_lane.sv]
// prc_rank_lane: one ranking lane; counts later smaller elements for its
// position and weights the count by the factorial constant. Uses prc_pkg.
module prc_rank_lane #(
  parameter int N   = prc_pkg::ELEM_COUNT_DEFAULT,
  parameter int POS = 0
) (
  input  logic                             clk,
  input  logic [N-1:0][prc_pkg::NIB_W-1:0] elems,
  output logic [prc_pkg::RANK_W-1:0]       prod
);

  localparam int CW = $clog2(N);
  localparam int PW = prc_pkg::RANK_W + CW;
  localparam logic [63:0] WFULL = prc_pkg::fact(N - 1 - POS);
  // only the low rank bits survive the final mask
  localparam logic [prc_pkg::RANK_W-1:0] WLOW = WFULL[prc_pkg::RANK_W-1:0];

  logic [CW-1:0] cnt_next;
  logic [CW-1:0] cnt;
  logic [PW-1:0] prod_full;

  always_comb begin
    cnt_next = '0;
    for (int j = POS + 1; j < N; j++) begin
      cnt_next = cnt_next + CW'(elems[j] < elems[POS]);
    end
  end

  assign prod_full = PW'(cnt) * PW'(WLOW);

  always_ff @(posedge clk) begin
    cnt  <= cnt_next;
    prod <= prod_full[prc_pkg::RANK_W-1:0];
  end

endmodule

[design/prc_unrank_stage.sv]
// prc_unrank_stage: one factorial digit of the unrank pipeline; peels the
// digit by constant compares and picks the digit-th unused value. Uses prc_pkg.
module prc_unrank_stage #(
  parameter int N   = prc_pkg::ELEM_COUNT_DEFAULT,
  parameter int IDX = 0
) (
  input  logic                        clk,
  input  logic [prc_pkg::RANK_W-1:0]  r_in,
  input  logic [N-1:0]                used_in,
  input  logic [prc_pkg::PERM_W-1:0]  perm_in,
  output logic [prc_pkg::RANK_W-1:0]  r,
  output logic [N-1:0]                used,
  output logic [prc_pkg::PERM_W-1:0]  perm
);

  localparam int AVAIL = N - IDX;
  localparam int DW    = $clog2(N);
  localparam logic [63:0] W = prc_pkg::fact(N - 1 - IDX);

  logic [DW-1:0]                d;
  logic [prc_pkg::RANK_W-1:0]   sub;
  logic [N-1:0]                 sel;
  logic [prc_pkg::PERM_W-1:0]   perm_next;

  // digit = number of multiples k*W, 1 <= k < AVAIL, not above r
  always_comb begin
    logic [63:0] mult;
    d   = '0;
    sub = '0;
    for (int k = 1; k < AVAIL; k++) begin
      mult = 64'(k) * W;
      if (64'(r_in) >= mult) begin
        d   = d + DW'(1);
        sub = mult[prc_pkg::RANK_W-1:0];
      end
    end
  end

  // one-hot pick: unused value with exactly d unused values below it
  always_comb begin
    logic [DW-1:0] below;
    for (int v = 0; v < N; v++) begin
      below = '0;
      for (int u = 0; u < v; u++) begin
        below = below + DW'(!used_in[u]);
      end
      sel[v] = !used_in[v] && (below == d);
    end
  end

  generate
    if (IDX < prc_pkg::NIB_COUNT) begin : g_nib
      logic [prc_pkg::NIB_W-1:0] val;
      always_comb begin
        val = '0;
        for (int v = 0; v < N; v++) begin
          if (sel[v]) begin
            val = val | prc_pkg::NIB_W'(v + 1);
          end
        end
        perm_next = perm_in;
        perm_next[prc_pkg::NIB_W*IDX +: prc_pkg::NIB_W] = val;
      end
    end else begin : g_nonib
      assign perm_next = perm_in;
    end
  endgenerate

  always_ff @(posedge clk) begin
    r    <= r_in - sub;
    used <= used_in | sel;
    perm <= perm_next;
  end

endmodule

[design/permutation_rank_codec.sv]
// permutation_rank_codec: Lehmer-code ranking and unranking of permutations.
// Depends on prc_pkg, prc_rank_lane, prc_unrank_stage.
//
// Usage:
//   An item is transferred when start is high and busy is low; busy stays
//   low, so one item may be issued every clock. action selects the mode:
//   rank perm_word (nine nibbles, position 1 in bits 3:0) into rank_out, or
//   unrank rank_in into perm_out. A rank_in of ELEMENT_COUNT! or more raises
//   range_error with perm_out zero. Fields not belonging to the mode are zero.
//   Each result appears on rank_out/perm_out/range_error for exactly one
//   cycle with done high, in issue order.
//   Unranking is one pipeline stage per factorial digit; ranking is a lane
//   per position but the last, a product stage and a merge sum, padded to
//   the same depth as unranking. Throughput is one item per cycle.
//   Reset (rst, synchronous) drops all items in flight; no result follows.
//   The receiver has no flow control and must take every result.
module permutation_rank_codec #(
  parameter int ELEMENT_COUNT = prc_pkg::ELEM_COUNT_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic                       action,
  input  logic [prc_pkg::PERM_W-1:0] perm_word,
  input  logic [prc_pkg::RANK_W-1:0] rank_in,
  output logic                       done,
  output logic [prc_pkg::RANK_W-1:0] rank_out,
  output logic [prc_pkg::PERM_W-1:0] perm_out,
  output logic                       range_error
);

  localparam int N    = ELEMENT_COUNT;
  localparam int LAT  = (N > prc_pkg::RANK_LAT) ? N : prc_pkg::RANK_LAT;
  localparam int RDLY = LAT - prc_pkg::RANK_LAT;
  localparam int UDLY = LAT - N;
  localparam logic [63:0] FACT_N = prc_pkg::fact(N);

  prc_pkg::prc_ctl_t ctl [LAT];
  logic [N-1:0][prc_pkg::NIB_W-1:0] elems;
  logic [prc_pkg::RANK_W-1:0] prod [N-1];
  logic [prc_pkg::RANK_W-1:0] sum_next;
  logic [prc_pkg::RANK_W-1:0] rank_sum;
  logic [prc_pkg::RANK_W-1:0] rank_al;
  logic [prc_pkg::PERM_W-1:0] perm_al;
  logic [prc_pkg::RANK_W-1:0] ur    [N+1];
  logic [N-1:0]               uused [N+1];
  logic [prc_pkg::PERM_W-1:0] uperm [N+1];

  assign busy = 1'b0;

  // control pipe
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < LAT; k++) begin
        ctl[k] <= '0;
      end
    end else begin
      ctl[0].vld <= start && !busy;
      ctl[0].act <= prc_pkg::prc_action_t'(action);
      ctl[0].err <= 64'(rank_in) >= FACT_N;
      for (int k = 1; k < LAT; k++) begin
        ctl[k] <= ctl[k-1];
      end
    end
  end

  // rank lanes
  genvar i;
  generate
    for (i = 0; i < N; i++) begin : g_elem
      if (i < prc_pkg::NIB_COUNT) begin : g_in
        assign elems[i] = perm_word[prc_pkg::NIB_W*i +: prc_pkg::NIB_W];
      end else begin : g_zero
        assign elems[i] = '0;
      end
    end
    for (i = 0; i < N - 1; i++) begin : g_lane
      prc_rank_lane #(.N(N), .POS(i)) u_lane (
        .clk   (clk),
        .elems (elems),
        .prod  (prod[i])
      );
    end
  endgenerate

  // merge: sum wraps at the rank width
  always_comb begin
    sum_next = '0;
    for (int k = 0; k < N - 1; k++) begin
      sum_next = sum_next + prod[k];
    end
  end

  always_ff @(posedge clk) begin
    rank_sum <= sum_next;
  end

  // unrank pipeline
  assign ur[0]    = rank_in;
  assign uused[0] = '0;
  assign uperm[0] = '0;

  generate
    for (i = 0; i < N; i++) begin : g_stage
      prc_unrank_stage #(.N(N), .IDX(i)) u_stage (
        .clk     (clk),
        .r_in    (ur[i]),
        .used_in (uused[i]),
        .perm_in (uperm[i]),
        .r       (ur[i+1]),
        .used    (uused[i+1]),
        .perm    (uperm[i+1])
      );
    end
  endgenerate

  // align both paths to LAT
  generate
    if (RDLY == 0) begin : g_rnodly
      assign rank_al = rank_sum;
    end else begin : g_rdly
      logic [prc_pkg::RANK_W-1:0] rd [RDLY];
      always_ff @(posedge clk) begin
        rd[0] <= rank_sum;
        for (int k = 1; k < RDLY; k++) begin
          rd[k] <= rd[k-1];
        end
      end
      assign rank_al = rd[RDLY-1];
    end
    if (UDLY == 0) begin : g_unodly
      assign perm_al = uperm[N];
    end else begin : g_udly
      logic [prc_pkg::PERM_W-1:0] pd [UDLY];
      always_ff @(posedge clk) begin
        pd[0] <= uperm[N];
        for (int k = 1; k < UDLY; k++) begin
          pd[k] <= pd[k-1];
        end
      end
      assign perm_al = pd[UDLY-1];
    end
  endgenerate

  always_comb begin
    done        = ctl[LAT-1].vld;
    rank_out    = '0;
    perm_out    = '0;
    range_error = 1'b0;
    unique case (ctl[LAT-1].act)
      prc_pkg::ACT_RANK: begin
        rank_out = rank_al;
      end
      prc_pkg::ACT_UNRANK: begin
        range_error = ctl[LAT-1].err;
        if (!ctl[LAT-1].err) begin
          perm_out = perm_al;
        end
      end
      default: begin
        rank_out = '0;
      end
    endcase
  end

endmodule

[test/prc_result_checker.sv]
`timescale 1ns / 1ps
// prc_result_checker: watches the issue and result channels of the permutation
// rank codec, predicts each result and compares it. Depends on prc_pkg.
module prc_result_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic                       busy,
  input  logic                       action,
  input  logic [prc_pkg::PERM_W-1:0] perm_word,
  input  logic [prc_pkg::RANK_W-1:0] rank_in,
  input  logic                       done,
  input  logic [prc_pkg::RANK_W-1:0] rank_out,
  input  logic [prc_pkg::PERM_W-1:0] perm_out,
  input  logic                       range_error,
  output int                         fail_count,
  output int                         outstanding
);

  localparam int N = prc_pkg::NIB_COUNT;

  typedef struct {
    logic [prc_pkg::RANK_W-1:0] rank;
    logic [prc_pkg::PERM_W-1:0] perm;
    logic                       err;
  } codec_result_t;

  codec_result_t pending_results[$];

  function automatic int unsigned factorial(int n);
    int unsigned f;
    f = 1;
    for (int k = n; k > 1; k--) f = f * k;
    return f;
  endfunction

  // Cantor expansion: later, strictly smaller elements weighted by (N-1-i)!
  function automatic logic [prc_pkg::RANK_W-1:0] lehmer_rank(
      logic [prc_pkg::PERM_W-1:0] word);
    logic [prc_pkg::NIB_W-1:0] elem [N];
    int unsigned sum;
    int unsigned smaller;
    sum = 0;
    for (int i = 0; i < N; i++) elem[i] = word[prc_pkg::NIB_W*i +: prc_pkg::NIB_W];
    for (int i = 0; i + 1 < N; i++) begin
      smaller = 0;
      for (int j = i + 1; j < N; j++)
        if (elem[j] < elem[i]) smaller++;
      sum += smaller * factorial(N - 1 - i);
    end
    return sum[prc_pkg::RANK_W-1:0];
  endfunction

  function automatic logic [prc_pkg::PERM_W-1:0] lehmer_unrank(
      logic [prc_pkg::RANK_W-1:0] r_in);
    logic [prc_pkg::NIB_W-1:0] pool [N];
    logic [prc_pkg::PERM_W-1:0] word;
    int avail;
    int rem;
    int digit;
    int wt;
    word = '0;
    avail = N;
    rem = int'(r_in);
    for (int i = 0; i < N; i++) pool[i] = prc_pkg::NIB_W'(i + 1);
    for (int i = 0; i < N; i++) begin
      wt = int'(factorial(N - 1 - i));
      digit = rem / wt;
      rem = rem % wt;
      if (digit >= avail) digit = avail - 1;
      word[prc_pkg::NIB_W*i +: prc_pkg::NIB_W] = pool[digit];
      for (int k = digit; k + 1 < avail; k++) pool[k] = pool[k + 1];
      avail--;
    end
    return word;
  endfunction

  function automatic codec_result_t predict_codec_result(prc_pkg::prc_action_t act,
      logic [prc_pkg::PERM_W-1:0] word, logic [prc_pkg::RANK_W-1:0] r_in);
    codec_result_t res;
    res.rank = '0;
    res.perm = '0;
    res.err  = 1'b0;
    if (act == prc_pkg::ACT_RANK) res.rank = lehmer_rank(word);
    else if (r_in >= factorial(N)) res.err = 1'b1;
    else res.perm = lehmer_unrank(r_in);
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    fail_count++;
  endtask

  initial fail_count = 0;
  initial outstanding = 0;

  always @(posedge clk) begin
    codec_result_t want;
    if (!rst) begin
      // results leave in issue order; none completes in its own issue cycle
      if (done) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result with nothing pending", 64'(rank_out), 64'd0);
        end else begin
          want = pending_results.pop_front();
          if (rank_out !== want.rank)
            report_mismatch("rank_out", 64'(rank_out), 64'(want.rank));
          if (perm_out !== want.perm)
            report_mismatch("perm_out", 64'(perm_out), 64'(want.perm));
          if (range_error !== want.err)
            report_mismatch("range_error", 64'(range_error), 64'(want.err));
        end
      end
      if (start && !busy)
        pending_results.push_back(predict_codec_result(
            prc_pkg::prc_action_t'(action), perm_word, rank_in));
    end
    outstanding <= pending_results.size();
  end

endmodule

[test/tb_permutation_rank_codec.sv]
`timescale 1ns / 1ps
// tb_permutation_rank_codec: stimulus and verdict for the permutation rank
// codec. Depends on prc_pkg, permutation_rank_codec and prc_result_checker.
module tb_permutation_rank_codec;

  localparam int PIPE_DEPTH  = 9;
  localparam int STALL_LIMIT = 5000;
  localparam int RANK_SPAN   = 362880;
  localparam int PHASE_ITEMS = 500;

  logic                       clk;
  logic                       rst;
  logic                       start;
  logic                       busy;
  logic                       action;
  logic [prc_pkg::PERM_W-1:0] perm_word;
  logic [prc_pkg::RANK_W-1:0] rank_in;
  logic                       done;
  logic [prc_pkg::RANK_W-1:0] rank_out;
  logic [prc_pkg::PERM_W-1:0] perm_out;
  logic                       range_error;
  int                         fail_count;
  int                         outstanding;
  int                         quiet_cycles;
  int                         idle_pct;
  int                         n_rank;
  int                         n_unrank;
  int                         n_out_of_range;

  permutation_rank_codec dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .action(action),
    .perm_word(perm_word), .rank_in(rank_in), .done(done), .rank_out(rank_out),
    .perm_out(perm_out), .range_error(range_error)
  );

  prc_result_checker u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .action(action),
    .perm_word(perm_word), .rank_in(rank_in), .done(done), .rank_out(rank_out),
    .perm_out(perm_out), .range_error(range_error), .fail_count(fail_count),
    .outstanding(outstanding)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // watchdog: cycles with neither an issue transfer nor a result
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [prc_pkg::PERM_W-1:0] random_word();
    logic [63:0] bits64;
    bits64 = {$urandom(), $urandom()};
    return bits64[prc_pkg::PERM_W-1:0];
  endfunction

  // shuffled 1..9, or nine distinct values out of 0..15
  function automatic logic [prc_pkg::PERM_W-1:0] shuffled_word(bit any_values);
    logic [prc_pkg::NIB_W-1:0] vals [16];
    logic [prc_pkg::NIB_W-1:0] tmp;
    logic [prc_pkg::PERM_W-1:0] word;
    int count;
    int j;
    count = any_values ? 16 : prc_pkg::NIB_COUNT;
    for (int k = 0; k < count; k++)
      vals[k] = any_values ? prc_pkg::NIB_W'(k) : prc_pkg::NIB_W'(k + 1);
    for (int k = count - 1; k > 0; k--) begin
      j = $urandom_range(k, 0);
      tmp = vals[k];
      vals[k] = vals[j];
      vals[j] = tmp;
    end
    for (int k = 0; k < prc_pkg::NIB_COUNT; k++)
      word[prc_pkg::NIB_W*k +: prc_pkg::NIB_W] = vals[k];
    return word;
  endfunction

  // idles per cycle at idle_pct, then holds the item until it is taken
  task automatic issue(prc_pkg::prc_action_t act, logic [prc_pkg::PERM_W-1:0] word,
                       logic [prc_pkg::RANK_W-1:0] r);
    while ($urandom_range(99, 0) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start     <= 1'b1;
    action    <= act;
    perm_word <= word;
    rank_in   <= r;
    if (act == prc_pkg::ACT_RANK) n_rank++;
    else if (r >= RANK_SPAN) n_out_of_range++;
    else n_unrank++;
    do @(posedge clk); while (busy);
  endtask

  // hold off the sender until every pending result has come back
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic random_phase(int pct);
    int pick;
    idle_pct = pct;
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      pick = $urandom_range(99, 0);
      if (pick < 40)
        issue(prc_pkg::ACT_RANK, shuffled_word(1'b0), prc_pkg::RANK_W'($urandom()));
      else if (pick < 50)
        issue(prc_pkg::ACT_RANK, shuffled_word(1'b1), prc_pkg::RANK_W'($urandom()));
      else if (pick < 58)
        issue(prc_pkg::ACT_RANK, random_word(), prc_pkg::RANK_W'($urandom()));
      else if (pick < 92)
        issue(prc_pkg::ACT_UNRANK, random_word(),
              prc_pkg::RANK_W'($urandom_range(RANK_SPAN - 1, 0)));
      else
        issue(prc_pkg::ACT_UNRANK, random_word(),
              prc_pkg::RANK_W'($urandom_range(524287, RANK_SPAN)));
    end
    drain();
  endtask

  initial begin
    rst            = 1'b1;
    start          = 1'b0;
    action         = prc_pkg::ACT_RANK;
    perm_word      = '0;
    rank_in        = '0;
    quiet_cycles   = 0;
    idle_pct       = 0;
    n_rank         = 0;
    n_unrank       = 0;
    n_out_of_range = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, repeated elements, arbitrary distinct values,
    // range boundary, back-to-back mode changes
    issue(prc_pkg::ACT_RANK,   36'h987654321, '0);
    issue(prc_pkg::ACT_RANK,   36'h123456789, '1);
    issue(prc_pkg::ACT_RANK,   36'h000000000, '0);
    issue(prc_pkg::ACT_RANK,   36'hFFFFFFFFF, '1);
    issue(prc_pkg::ACT_RANK,   36'h555533311, '0);
    issue(prc_pkg::ACT_RANK,   36'h112233445, '0);
    issue(prc_pkg::ACT_RANK,   36'hF0E1D2C3B, '0);
    issue(prc_pkg::ACT_RANK,   36'h0FEDCBA98, '0);
    issue(prc_pkg::ACT_RANK,   36'h89ABCDEF0, '1);
    issue(prc_pkg::ACT_UNRANK, '0, 19'd0);
    issue(prc_pkg::ACT_UNRANK, '1, 19'd1);
    issue(prc_pkg::ACT_UNRANK, '0, 19'd5039);
    issue(prc_pkg::ACT_UNRANK, '0, 19'd40320);
    issue(prc_pkg::ACT_UNRANK, '0, 19'(RANK_SPAN - 1));
    issue(prc_pkg::ACT_UNRANK, '1, 19'(RANK_SPAN));
    issue(prc_pkg::ACT_UNRANK, '0, 19'(RANK_SPAN + 1));
    issue(prc_pkg::ACT_UNRANK, '1, '1);
    issue(prc_pkg::ACT_RANK,   36'h918273645, '1);
    issue(prc_pkg::ACT_UNRANK, 36'h123456789, 19'd181440);
    issue(prc_pkg::ACT_RANK,   36'h987654312, '0);
    drain();

    random_phase(15);
    random_phase(81);
    random_phase(0);

    repeat (2 * PIPE_DEPTH) @(posedge clk);
    $display("Covered %0d rank items, %0d unrank items and %0d out-of-range ranks",
             n_rank, n_unrank, n_out_of_range);
    $display("under light, heavy and no sender idling, with drains between phases.");
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
